// File: rtl/core/pidtc_pkg.sv
// Package for the clamped PID core: payload structs, register indexes,
// sequencer states and datapath widths. Depends on nothing.
package pidtc_pkg;

    localparam int ERR_W      = 13;
    localparam int PAIR_W     = 14;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 21;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SPLIT      = 20;
    localparam int ESUM_W     = 39;
    localparam int RAW_W      = 40;
    localparam int TMP_W      = 37;
    localparam int ACC_W      = 62;
    localparam int TOT_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 39;

    localparam logic [1:0] STATUS_IN_RANGE  = 2'd0;
    localparam logic [1:0] STATUS_SATURATED = 2'd1;
    localparam logic [1:0] STATUS_ZERO      = 2'd2;

    typedef struct packed {
        logic [11:0] target;
        logic [11:0] measured;
    } in_t;

    typedef struct packed {
        logic [27:0] effort;
        logic [1:0]  clamp_status;
    } out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_SAMPLE_PERIOD  = 3'd3,
        REG_SAMPLE_RATE    = 3'd4,
        REG_INTEGRAL_UPPER = 3'd5,
        REG_INTEGRAL_LOWER = 3'd6,
        REG_SATURATION     = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_SUM,
        ST_CLAMP,
        ST_DLO,
        ST_DHI,
        ST_ILO,
        ST_IHI,
        ST_IACC,
        ST_ITOT,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/pid_trapezoid_clamped_core.sv
// Top level of the clamped PID core: configuration registers, controller
// state, sequencer and output register. Depends on pidtc_pkg and pidtc_mul.
//
// Each transfer on the input channel steps through the states INC, SUM,
// CLAMP, DLO, DHI, ILO, IHI, IACC, ITOT and OUT until the result is loaded into
// the output register, and the next transfer is accepted only back in IDLE:
// one 24 x 21 bit signed multiplier is used once per step for the integral
// increment, the derivative (gain, then rate in two halves), the
// proportional term and the integral term (two halves), with one accumulator
// summing the partial products. in_stall is high while an item is in flight,
// and also while a finished result waits in the output register and the next
// one is ready to be loaded. Configuration writes are always taken
// (cfg_ready is high).
module pid_trapezoid_clamped_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pidtc_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pidtc_pkg::out_t                     out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidtc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [22:0]        gain_p_reg;
    logic [22:0]        gain_i_reg;
    logic [22:0]        gain_d_reg;
    logic [16:0]        sample_period_reg;
    logic [22:0]        sample_rate_reg;
    logic [37:0]        integral_upper_reg;
    logic signed [38:0] integral_lower_reg;
    logic [27:0]        saturation_reg;

    logic signed [pidtc_pkg::ERR_W-1:0]  last_error_reg;
    logic signed [pidtc_pkg::ESUM_W-1:0] error_sum_reg, error_sum_next;

    pidtc_pkg::state_t state_reg, state_next;

    logic signed [pidtc_pkg::ERR_W-1:0]  err_reg, err_next;
    logic signed [pidtc_pkg::PAIR_W-1:0] diff_reg, diff_next;
    logic signed [pidtc_pkg::PAIR_W-1:0] psum_reg, psum_next;
    logic signed [pidtc_pkg::RAW_W-1:0]  sum_reg, sum_next;
    logic signed [pidtc_pkg::TMP_W-1:0]  tmp_reg, tmp_next;
    logic signed [pidtc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [pidtc_pkg::TOT_W-1:0]  total_reg, total_next;

    pidtc_pkg::out_t out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic signed [pidtc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pidtc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pidtc_pkg::PROD_W-1:0]  prod;

    logic                                in_xfer;
    logic signed [pidtc_pkg::ERR_W-1:0]  new_err;
    logic signed [pidtc_pkg::ACC_W-1:0]  prod_ext;
    logic signed [pidtc_pkg::ACC_W-1:0]  prod_hi;
    logic signed [pidtc_pkg::TOT_W-1:0]  acc_scaled;
    logic signed [pidtc_pkg::RAW_W-1:0]  upper_ext;
    logic signed [pidtc_pkg::RAW_W-1:0]  lower_ext;
    logic signed [pidtc_pkg::TOT_W-1:0]  sat_ext;

    function automatic logic signed [pidtc_pkg::PAIR_W-1:0] PAIR_EXT(
        input logic signed [pidtc_pkg::ERR_W-1:0] v
    );
        return {v[pidtc_pkg::ERR_W-1], v};
    endfunction

    pidtc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != pidtc_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign new_err = $signed({1'b0, in_data.target}) - $signed({1'b0, in_data.measured});

    assign prod_ext   = {{(pidtc_pkg::ACC_W-pidtc_pkg::PROD_W){prod[pidtc_pkg::PROD_W-1]}}, prod};
    assign prod_hi    = {prod[pidtc_pkg::ACC_W-pidtc_pkg::SPLIT-1:0],
                         {pidtc_pkg::SPLIT{1'b0}}};
    assign acc_scaled = {{(pidtc_pkg::TOT_W-pidtc_pkg::ACC_W+pidtc_pkg::FRAC_W)
                          {acc_reg[pidtc_pkg::ACC_W-1]}},
                         acc_reg[pidtc_pkg::ACC_W-1:pidtc_pkg::FRAC_W]};
    assign upper_ext  = $signed({2'b00, integral_upper_reg});
    assign lower_ext  = {integral_lower_reg[38], integral_lower_reg};
    assign sat_ext    = $signed({20'd0, saturation_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            sample_period_reg  <= 17'd65536;
            sample_rate_reg    <= 23'd65536;
            integral_upper_reg <= 38'd216268800000;
            integral_lower_reg <= -39'sd216268800000;
            saturation_reg     <= 28'd216268800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pidtc_pkg::cfg_reg_t'(cfg_index))
                pidtc_pkg::REG_GAIN_P:         gain_p_reg         <= cfg_data[22:0];
                pidtc_pkg::REG_GAIN_I:         gain_i_reg         <= cfg_data[22:0];
                pidtc_pkg::REG_GAIN_D:         gain_d_reg         <= cfg_data[22:0];
                pidtc_pkg::REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data[16:0];
                pidtc_pkg::REG_SAMPLE_RATE:    sample_rate_reg    <= cfg_data[22:0];
                pidtc_pkg::REG_INTEGRAL_UPPER: integral_upper_reg <= cfg_data[37:0];
                pidtc_pkg::REG_INTEGRAL_LOWER: integral_lower_reg <= cfg_data[38:0];
                pidtc_pkg::REG_SATURATION:     saturation_reg     <= cfg_data[27:0];
                default:                       saturation_reg     <= saturation_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pidtc_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            error_sum_reg <= error_sum_next;
            if (in_xfer)
            begin
                last_error_reg <= new_err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        psum_reg  <= psum_next;
        sum_reg   <= sum_next;
        tmp_reg   <= tmp_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        psum_next      = psum_reg;
        sum_next       = sum_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        error_sum_next = error_sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pidtc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next   = new_err;
                    diff_next  = PAIR_EXT(new_err) - PAIR_EXT(last_error_reg);
                    psum_next  = PAIR_EXT(new_err) + PAIR_EXT(last_error_reg);
                    state_next = pidtc_pkg::ST_INC;
                end
            end
            pidtc_pkg::ST_INC:
            begin
                mul_a      = $signed({7'd0, sample_period_reg});
                mul_b      = {{(pidtc_pkg::MUL_B_W-pidtc_pkg::PAIR_W){psum_reg[13]}}, psum_reg};
                state_next = pidtc_pkg::ST_SUM;
            end
            pidtc_pkg::ST_SUM:
            begin
                mul_a      = $signed({1'b0, gain_d_reg});
                mul_b      = {{(pidtc_pkg::MUL_B_W-pidtc_pkg::PAIR_W){diff_reg[13]}}, diff_reg};
                sum_next   = {error_sum_reg[pidtc_pkg::ESUM_W-1], error_sum_reg}
                             + prod[pidtc_pkg::RAW_W:1];
                state_next = pidtc_pkg::ST_CLAMP;
            end
            pidtc_pkg::ST_CLAMP:
            begin
                mul_a    = $signed({1'b0, gain_p_reg});
                mul_b    = {{(pidtc_pkg::MUL_B_W-pidtc_pkg::ERR_W){err_reg[12]}}, err_reg};
                tmp_next = prod[pidtc_pkg::TMP_W-1:0];
                priority if (sum_reg > upper_ext)
                begin
                    error_sum_next = upper_ext[pidtc_pkg::ESUM_W-1:0];
                end
                else if (sum_reg < lower_ext)
                begin
                    error_sum_next = integral_lower_reg;
                end
                else
                begin
                    error_sum_next = sum_reg[pidtc_pkg::ESUM_W-1:0];
                end
                state_next = pidtc_pkg::ST_DLO;
            end
            pidtc_pkg::ST_DLO:
            begin
                mul_a      = $signed({1'b0, sample_rate_reg});
                mul_b      = $signed({1'b0, tmp_reg[pidtc_pkg::SPLIT-1:0]});
                total_next = prod_ext[pidtc_pkg::TOT_W-1:0];
                state_next = pidtc_pkg::ST_DHI;
            end
            pidtc_pkg::ST_DHI:
            begin
                mul_a      = $signed({1'b0, sample_rate_reg});
                mul_b      = {{(pidtc_pkg::MUL_B_W-pidtc_pkg::TMP_W+pidtc_pkg::SPLIT)
                               {tmp_reg[pidtc_pkg::TMP_W-1]}},
                              tmp_reg[pidtc_pkg::TMP_W-1:pidtc_pkg::SPLIT]};
                acc_next   = prod_ext;
                state_next = pidtc_pkg::ST_ILO;
            end
            pidtc_pkg::ST_ILO:
            begin
                mul_a      = $signed({1'b0, gain_i_reg});
                mul_b      = $signed({1'b0, error_sum_reg[pidtc_pkg::SPLIT-1:0]});
                acc_next   = acc_reg + prod_hi;
                state_next = pidtc_pkg::ST_IHI;
            end
            pidtc_pkg::ST_IHI:
            begin
                mul_a      = $signed({1'b0, gain_i_reg});
                mul_b      = {{(pidtc_pkg::MUL_B_W-pidtc_pkg::ESUM_W+pidtc_pkg::SPLIT)
                               {error_sum_reg[pidtc_pkg::ESUM_W-1]}},
                              error_sum_reg[pidtc_pkg::ESUM_W-1:pidtc_pkg::SPLIT]};
                total_next = total_reg + acc_scaled;
                acc_next   = prod_ext;
                state_next = pidtc_pkg::ST_IACC;
            end
            pidtc_pkg::ST_IACC:
            begin
                acc_next   = acc_reg + prod_hi;
                state_next = pidtc_pkg::ST_ITOT;
            end
            pidtc_pkg::ST_ITOT:
            begin
                total_next = total_reg + acc_scaled;
                state_next = pidtc_pkg::ST_OUT;
            end
            pidtc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    priority if (total_reg >= sat_ext)
                    begin
                        out_next.effort       = saturation_reg;
                        out_next.clamp_status = pidtc_pkg::STATUS_SATURATED;
                    end
                    else if (total_reg < 0)
                    begin
                        out_next.effort       = '0;
                        out_next.clamp_status = pidtc_pkg::STATUS_ZERO;
                    end
                    else
                    begin
                        out_next.effort       = total_reg[27:0];
                        out_next.clamp_status = pidtc_pkg::STATUS_IN_RANGE;
                    end
                    out_valid_next = 1'b1;
                    state_next     = pidtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidtc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pidtc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pidtc_pkg for operand and product widths.
module pidtc_mul (
    input  logic                                   clk,
    input  logic signed [pidtc_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pidtc_pkg::MUL_B_W-1:0]   b,
    output logic signed [pidtc_pkg::PROD_W-1:0]    prod
);

    logic signed [pidtc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
